### src/lrrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrq_pkg
// Shared types and constants for the Lamport resource request queue.
// ----------------------------------------------------------------------------
package lrrq_pkg;

    localparam int MAX_NODES  = 8;
    localparam int CLOCK_BITS = 32;

    localparam int ID_W       = 3;
    localparam int UNITS_W    = 8;
    localparam int MSG_CLK_W  = 32;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    localparam int IDX_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CMP_W   = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;
    localparam int ENTRY_W = CLOCK_BITS + UNITS_W;

    localparam logic [ID_W-1:0]    OWN_ID_RST      = 3'd0;
    localparam logic [UNITS_W-1:0] TOTAL_UNITS_RST = 8'd7;
    localparam logic [UNITS_W-1:0] OWN_NEED_RST    = 8'd1;

    typedef enum logic [OP_W-1:0] {
        OP_REMOTE_REQ = 2'd0,
        OP_REMOTE_REL = 2'd1,
        OP_LOCAL_REQ  = 2'd2,
        OP_LOCAL_REL  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OWN_ID      = 2'd0,
        REG_TOTAL_UNITS = 2'd1,
        REG_OWN_NEED    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             load_in;
        logic             update;
        logic             rd_own;
        logic             load_own;
        logic             acc;
        logic             load_out;
        logic [IDX_W-1:0] rd_idx;
        logic [IDX_W-1:0] acc_idx;
    } lrrq_cmd_t;

    typedef struct packed {
        logic out_free;
    } lrrq_stat_t;

endpackage

### src/lrrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lrrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### src/lrrq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrq_ctrl
// Sequencer: update, own entry lookup, table scan and result hand-off.
// ----------------------------------------------------------------------------
module lrrq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lrrq_pkg::lrrq_stat_t stat,
    output lrrq_pkg::lrrq_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_OWN_RD,
        ST_OWN_LD,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t                        state_reg, state_next;
    logic [lrrq_pkg::IDX_W-1:0]    cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_OWN_RD;
            end
            ST_OWN_RD: begin
                cmd.rd_own = 1'b1;
                state_next = ST_OWN_LD;
            end
            ST_OWN_LD: begin
                cmd.load_own = 1'b1;
                cmd.rd_idx   = '0;
                cnt_next     = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.acc     = 1'b1;
                cmd.acc_idx = cnt_reg;
                cmd.rd_idx  = cnt_reg + lrrq_pkg::IDX_W'(1);
                if (cnt_reg == lrrq_pkg::IDX_W'(lrrq_pkg::MAX_NODES - 1)) begin
                    state_next = ST_RESULT;
                end else begin
                    cnt_next = cnt_reg + lrrq_pkg::IDX_W'(1);
                end
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### src/lrrq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrq_dp
// Datapath: configuration, Lamport clock, request table and result register.
// ----------------------------------------------------------------------------
module lrrq_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lrrq_pkg::lrrq_cmd_t                 cmd,
    output lrrq_pkg::lrrq_stat_t                stat,
    input  logic [lrrq_pkg::OP_W-1:0]           in_op,
    input  logic [lrrq_pkg::MSG_CLK_W-1:0]      in_msg_clock,
    input  logic [lrrq_pkg::ID_W-1:0]           in_node_id,
    input  logic [lrrq_pkg::UNITS_W-1:0]        in_msg_units,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrrq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lrrq_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lrrq_pkg::MSG_CLK_W-1:0]      m_logical_clock,
    output logic [lrrq_pkg::UNITS_W-1:0]        m_free_units,
    output logic                                m_granted,
    output logic                                m_own_pending
);

    localparam int CB = lrrq_pkg::CLOCK_BITS;
    localparam int UW = lrrq_pkg::UNITS_W;
    localparam int IW = lrrq_pkg::IDX_W;
    localparam int CW = lrrq_pkg::CMP_W;

    // configuration
    logic [lrrq_pkg::ID_W-1:0] own_id_reg;
    logic [UW-1:0]             total_units_reg;
    logic [UW-1:0]             own_need_reg;

    // latched item
    lrrq_pkg::op_t             op_reg;
    logic [CB-1:0]             mclk_reg;
    logic [lrrq_pkg::ID_W-1:0] sender_reg;
    logic [UW-1:0]             munits_reg;

    logic [CB-1:0]             clock_reg, clock_next;
    logic [lrrq_pkg::MAX_NODES-1:0] valid_reg, valid_next;
    logic [CB-1:0]             own_stamp_reg;
    logic                      have_own_reg;
    logic [UW-1:0]             free_reg, free_next;
    logic                      m_valid_reg;

    logic                      own_ok, sender_ok;
    logic [IW-1:0]             own_idx, sender_idx;
    logic [CB-1:0]             clock_inc, clock_max;

    logic                      ram_we;
    logic [IW-1:0]             ram_waddr, ram_raddr;
    logic [lrrq_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [CB-1:0]             rd_stamp;
    logic [UW-1:0]             rd_units;
    logic                      before_own, skip;

    assign cfg_ready  = 1'b1;
    assign own_ok     = (CW'(own_id_reg) < CW'(lrrq_pkg::MAX_NODES));
    assign sender_ok  = (CW'(sender_reg) < CW'(lrrq_pkg::MAX_NODES));
    assign own_idx    = IW'(own_id_reg);
    assign sender_idx = IW'(sender_reg);
    assign clock_inc  = clock_reg + CB'(1);
    assign clock_max  = (mclk_reg > clock_reg) ? mclk_reg : clock_reg;

    // event update
    always_comb begin
        clock_next = clock_reg;
        valid_next = valid_reg;
        ram_we     = 1'b0;
        ram_waddr  = own_idx;
        ram_wdata  = {own_need_reg, clock_inc};
        case (op_reg)
            lrrq_pkg::OP_REMOTE_REQ: begin
                clock_next = clock_max + CB'(1);
                ram_waddr  = sender_idx;
                ram_wdata  = {munits_reg, mclk_reg};
                if (sender_ok) begin
                    ram_we                 = cmd.update;
                    valid_next[sender_idx] = 1'b1;
                end
            end
            lrrq_pkg::OP_REMOTE_REL: begin
                clock_next = clock_inc;
                if (sender_ok) begin
                    valid_next[sender_idx] = 1'b0;
                end
            end
            lrrq_pkg::OP_LOCAL_REQ: begin
                clock_next = clock_inc;
                if (own_ok) begin
                    ram_we              = cmd.update;
                    valid_next[own_idx] = 1'b1;
                end
            end
            default: begin
                if (own_ok) begin
                    valid_next[own_idx] = 1'b0;
                end
            end
        endcase
    end

    assign ram_raddr = cmd.rd_own ? own_idx : cmd.rd_idx;

    lrrq_ram #(
        .WIDTH (lrrq_pkg::ENTRY_W),
        .DEPTH (lrrq_pkg::MAX_NODES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_stamp = ram_rdata[CB-1:0];
    assign rd_units = ram_rdata[CB +: UW];

    // ordering against the own request, then saturating subtract
    always_comb begin
        before_own = (rd_stamp < own_stamp_reg) ||
                     ((rd_stamp == own_stamp_reg) &&
                      (CW'(cmd.acc_idx) < CW'(own_id_reg)));
        skip = !valid_reg[cmd.acc_idx] ||
               (have_own_reg &&
                ((CW'(cmd.acc_idx) == CW'(own_id_reg)) || !before_own));
        if (skip) begin
            free_next = free_reg;
        end else if (rd_units >= free_reg) begin
            free_next = '0;
        end else begin
            free_next = free_reg - rd_units;
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg      <= lrrq_pkg::OWN_ID_RST;
            total_units_reg <= lrrq_pkg::TOTAL_UNITS_RST;
            own_need_reg    <= lrrq_pkg::OWN_NEED_RST;
            clock_reg       <= '0;
            valid_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    lrrq_pkg::REG_OWN_ID:      own_id_reg      <= cfg_data[lrrq_pkg::ID_W-1:0];
                    lrrq_pkg::REG_TOTAL_UNITS: total_units_reg <= cfg_data;
                    lrrq_pkg::REG_OWN_NEED:    own_need_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.update) begin
                clock_reg <= clock_next;
                valid_reg <= valid_next;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg     <= lrrq_pkg::op_t'(in_op);
            mclk_reg   <= CB'(in_msg_clock);
            sender_reg <= in_node_id;
            munits_reg <= in_msg_units;
        end
        if (cmd.load_own) begin
            own_stamp_reg <= rd_stamp;
            have_own_reg  <= own_ok && valid_reg[own_idx];
            free_reg      <= total_units_reg;
        end else if (cmd.acc) begin
            free_reg <= free_next;
        end
        if (cmd.load_out) begin
            m_logical_clock <= lrrq_pkg::MSG_CLK_W'(clock_reg);
            m_free_units    <= free_reg;
            m_granted       <= have_own_reg && (free_reg >= own_need_reg);
            m_own_pending   <= have_own_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### src/lamport_resource_request_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamport_resource_request_queue_core
// One node of Lamport-ordered mutual exclusion over a pool of units.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one event per item, tuser = op (remote request, remote
//   release, local request, local release), tdata = timestamp, sender, units
//   m_ channel: one result per event with the Lamport clock, the units left
//   free by requests ordered ahead of the own one (or by all if none), grant and pending flags
//   cfg channel: own id, pool size and own need; write only while idle
//   m_tvalid rises after an item has gone through the update, own entry
//   read, own entry load, table scan and result steps, one item at a time;
//   the table scan reads one entry a cycle through the entry ram read port
//   a new item is taken while the previous result still waits on m_tready;
//   it then holds in its last step until the output register frees up
//   reset clears the clock, all entry valid bits and the output valid flag,
//   and loads the configuration reset values; no clearing pass is needed
// ----------------------------------------------------------------------------
module lamport_resource_request_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // msg_clock[31:0], node_id[34:32], msg_units[42:35]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // logical_clock[31:0], free_units[39:32], granted[40], own_pending[41]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    lrrq_pkg::lrrq_cmd_t  cmd;
    lrrq_pkg::lrrq_stat_t stat;

    logic [lrrq_pkg::MSG_CLK_W-1:0] logical_clock;
    logic [lrrq_pkg::UNITS_W-1:0]   free_units;
    logic                           granted;
    logic                           own_pending;

    lrrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrrq_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (s_tuser),
        .in_msg_clock    (s_tdata[31:0]),
        .in_node_id      (s_tdata[34:32]),
        .in_msg_units    (s_tdata[42:35]),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .m_logical_clock (logical_clock),
        .m_free_units    (free_units),
        .m_granted       (granted),
        .m_own_pending   (own_pending)
    );

    assign m_tdata = {6'd0, own_pending, granted, free_units, logical_clock};

    a_grant_needs_own : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[40] && !m_tdata[41]))
        else $error("grant without own request");

    a_accept_starts_update : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.update)
        else $error("accepted item not followed by update");

    a_no_result_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded over pending result");

endmodule
